// ===== rtl/sacb_pkg.sv =====
package sacb_pkg;

    // Frame counter width and the width used to compare counters with 16-bit registers
    localparam int COUNT_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int CMP_W      = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_FRAMES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW        = 3'd6;

    // Register reset values
    localparam logic [13:0] RST_DEADZONE     = 14'd4500;
    localparam logic [15:0] RST_RESET_FRAMES = 16'd6;
    localparam logic [15:0] RST_THRESHOLD    = 16'd10;
    localparam logic [15:0] RST_RAMP         = 16'd30;
    localparam logic [9:0]  RST_BOOST_MIN    = 10'd100;
    localparam logic [9:0]  RST_BOOST_MAX    = 10'd200;
    localparam logic [6:0]  RST_SLOW         = 7'd50;

    // Curve breakpoints (magnitude) and speeds in hundredths
    localparam logic [15:0] PREC_END  = 16'd12000;
    localparam logic [15:0] LIN_END   = 16'd22000;
    localparam logic [15:0] ACCEL_END = 16'd30000;
    localparam logic [15:0] MAG_TOP   = 16'd32767;
    localparam logic [11:0] PREC_MIN_X100  = 12'd50;
    localparam logic [11:0] PREC_MAX_X100  = 12'd200;
    localparam logic [11:0] LIN_MIN_X100   = 12'd200;
    localparam logic [11:0] LIN_MAX_X100   = 12'd800;
    localparam logic [11:0] ACCEL_MIN_X100 = 12'd800;
    localparam logic [11:0] BURST_MIN_X100 = 12'd2400;
    localparam logic [11:0] BURST_MAX_X100 = 12'd4000;
    localparam logic [15:0] PERCENT        = 16'd100;
    localparam logic [8:0]  SPEED_LIMIT    = 9'd511;

    // Shared divider: numerator and denominator widths, quotient bits per cycle
    localparam int NUM_W     = 26;
    localparam int DEN_W     = 16;
    localparam int DIV_STEP  = 2;
    localparam int DIV_CYC   = NUM_W / DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_CYC);

    // Multiply-divide operations of one transaction, in issue order
    typedef enum logic [2:0] {
        OP_ZONE,
        OP_TSQ,
        OP_BOOST,
        OP_VAL,
        OP_SLOW,
        OP_PIX
    } t_op;

    typedef struct packed {
        logic accept;
        logic update;
        logic mul;
        logic start;
        logic wb;
        logic out_load;
        t_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic dead;
        logic quad;
        logic boost_direct;
        logic slow;
        logic val_ge100;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/sacb_div.sv =====
module sacb_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sacb_pkg::NUM_W-1:0]  i_num,
    input  logic [sacb_pkg::DEN_W-1:0]  i_den,
    output logic                        o_done,
    output logic [sacb_pkg::NUM_W-1:0]  o_quot
);
    import sacb_pkg::*;

    logic [DEN_W-1:0]     r_rem;
    logic [NUM_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DEN_W-1:0]     n_rem;
    logic [NUM_W-1:0]     n_quo;

    // Restoring division, DIV_STEP quotient bits per cycle
    always_comb begin : div_step
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] quo;
        logic [DEN_W:0]   trial;
        rem   = r_rem;
        quo   = r_quo;
        trial = '0;
        for (int k = 0; k < DIV_STEP; k++) begin
            trial = {rem, quo[NUM_W-1]};
            quo   = {quo[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, i_den}) begin
                trial  = trial - {1'b0, i_den};
                quo[0] = 1'b1;
            end
            rem = trial[DEN_W-1:0];
        end
        n_rem = rem;
        n_quo = quo;
    end

    // Load on start, iterate while busy, flag the last step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== rtl/sacb_dp.sv =====
module sacb_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sacb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sacb_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic signed [15:0]              i_deflection,
    input  logic                            i_slow_mode,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic signed [9:0]               o_speed,
    input  sacb_pkg::t_dp_cmd               i_cmd,
    output sacb_pkg::t_dp_sts               o_sts
);
    import sacb_pkg::*;

    typedef enum logic [1:0] {DIR_NONE, DIR_POS, DIR_NEG} t_dir;
    typedef enum logic [1:0] {Z_PREC, Z_LIN, Z_ACCEL, Z_BURST} t_zone;

    // Configuration registers
    logic [13:0] r_deadzone;
    logic [15:0] r_reset_frames;
    logic [15:0] r_threshold;
    logic [15:0] r_ramp;
    logic [9:0]  r_boost_min;
    logic [9:0]  r_boost_max;
    logic [6:0]  r_slow_x100;

    // Sample and boost state
    logic [15:0]           r_mag;
    t_dir                  r_dir;
    logic                  r_slow;
    logic [COUNT_BITS-1:0] r_dead_cnt;
    logic [COUNT_BITS-1:0] r_held_cnt;
    t_dir                  r_held_dir;

    // Working registers
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [11:0]      r_spd;
    logic [6:0]       r_t;
    logic [9:0]       r_boost;
    logic [15:0]      r_val;
    logic [8:0]       r_pix;
    logic             r_out_valid;
    logic signed [9:0] r_speed;

    logic [15:0]           w_in_mag;
    t_dir                  w_in_dir;
    logic                  w_dead;
    t_zone                 w_zone;
    logic [15:0]           w_mag_cl;
    logic [COUNT_BITS-1:0] w_dead_inc;
    logic [COUNT_BITS-1:0] w_held_inc;
    logic [CMP_W-1:0]      w_held_ext;
    logic [CMP_W-1:0]      w_pos;
    logic                  w_below_thr;
    logic                  w_full;
    logic                  w_span_neg;
    logic [9:0]            w_span_mag;
    logic [15:0]           w_mul_a;
    logic [15:0]           w_mul_b;
    logic [DEN_W-1:0]      w_den;
    logic [31:0]           w_prod;
    logic                  w_div_done;
    logic [NUM_W-1:0]      w_quot;
    logic [15:0]           w_pix_raw;
    logic [9:0]            w_pix_ext;

    // Magnitude and direction of the incoming sample
    assign w_in_mag = i_deflection[15] ? (~$unsigned(i_deflection) + 16'd1)
                                       : $unsigned(i_deflection);
    assign w_in_dir = i_deflection[15] ? DIR_NEG
                    : ((i_deflection != 16'sd0) ? DIR_POS : DIR_NONE);

    // Zone decode
    assign w_dead   = r_mag < {2'b00, r_deadzone};
    assign w_mag_cl = (r_mag > MAG_TOP) ? MAG_TOP : r_mag;
    always_comb begin
        priority if (r_mag < PREC_END) w_zone = Z_PREC;
        else if (r_mag < LIN_END)      w_zone = Z_LIN;
        else if (r_mag < ACCEL_END)    w_zone = Z_ACCEL;
        else                           w_zone = Z_BURST;
    end

    // Saturating frame counters
    assign w_dead_inc = (&r_dead_cnt) ? r_dead_cnt : r_dead_cnt + 1'b1;
    assign w_held_inc = (&r_held_cnt) ? r_held_cnt : r_held_cnt + 1'b1;

    // Boost ramp position
    assign w_held_ext  = CMP_W'(r_held_cnt);
    assign w_below_thr = w_held_ext < CMP_W'(r_threshold);
    assign w_pos       = w_held_ext - CMP_W'(r_threshold);
    assign w_full      = w_pos >= CMP_W'(r_ramp);
    assign w_span_neg  = r_boost_max < r_boost_min;
    assign w_span_mag  = w_span_neg ? (r_boost_min - r_boost_max) : (r_boost_max - r_boost_min);

    // Select multiplier operands and divisor for the current operation
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        w_den   = PERCENT;
        unique case (i_cmd.op)
            OP_ZONE: begin
                unique case (w_zone)
                    Z_PREC: begin
                        w_mul_a = r_mag - {2'b00, r_deadzone};
                        w_mul_b = 16'(PREC_MAX_X100 - PREC_MIN_X100);
                        w_den   = PREC_END - {2'b00, r_deadzone};
                    end
                    Z_LIN: begin
                        w_mul_a = r_mag - PREC_END;
                        w_mul_b = 16'(LIN_MAX_X100 - LIN_MIN_X100);
                        w_den   = LIN_END - PREC_END;
                    end
                    Z_ACCEL: begin
                        w_mul_a = r_mag - LIN_END;
                        w_mul_b = PERCENT;
                        w_den   = ACCEL_END - LIN_END;
                    end
                    Z_BURST: begin
                        w_mul_a = w_mag_cl - ACCEL_END;
                        w_mul_b = 16'(BURST_MAX_X100 - BURST_MIN_X100);
                        w_den   = MAG_TOP - ACCEL_END;
                    end
                    default: ;
                endcase
            end
            OP_TSQ: begin
                w_mul_a = {9'b0, r_t};
                w_mul_b = {9'b0, r_t};
            end
            OP_BOOST: begin
                w_mul_a = w_pos[15:0];
                w_mul_b = {6'b0, w_span_mag};
                w_den   = r_ramp;
            end
            OP_VAL: begin
                w_mul_a = {4'b0, r_spd};
                w_mul_b = {6'b0, r_boost};
            end
            OP_SLOW: begin
                w_mul_a = r_val;
                w_mul_b = {9'b0, r_slow_x100};
            end
            OP_PIX: begin
                w_mul_a = r_val;
                w_mul_b = 16'd1;
            end
            default: ;
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    sacb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Whole pixels: round a nonzero fraction up to one, saturate
    assign w_pix_raw = (r_val >= PERCENT) ? w_quot[15:0] : {15'b0, (r_val != 16'd0)};
    assign w_pix_ext = {1'b0, r_pix};

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone     <= RST_DEADZONE;
            r_reset_frames <= RST_RESET_FRAMES;
            r_threshold    <= RST_THRESHOLD;
            r_ramp         <= RST_RAMP;
            r_boost_min    <= RST_BOOST_MIN;
            r_boost_max    <= RST_BOOST_MAX;
            r_slow_x100    <= RST_SLOW;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEADZONE:     r_deadzone     <= i_cfg_data[13:0];
                CFG_RESET_FRAMES: r_reset_frames <= i_cfg_data;
                CFG_THRESHOLD:    r_threshold    <= i_cfg_data;
                CFG_RAMP:         r_ramp         <= i_cfg_data;
                CFG_BOOST_MIN:    r_boost_min    <= i_cfg_data[9:0];
                CFG_BOOST_MAX:    r_boost_max    <= i_cfg_data[9:0];
                CFG_SLOW:         r_slow_x100    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Boost integrator: count dead frames, held frames and direction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_cnt <= '0;
            r_held_cnt <= '0;
            r_held_dir <= DIR_NONE;
        end else if (i_cmd.update) begin
            if (w_dead) begin
                r_dead_cnt <= w_dead_inc;
                if (CMP_W'(w_dead_inc) >= CMP_W'(r_reset_frames)) begin
                    r_held_cnt <= '0;
                    r_held_dir <= DIR_NONE;
                end
            end else begin
                r_dead_cnt <= '0;
                if (r_held_dir != DIR_NONE && r_held_dir == r_dir) begin
                    r_held_cnt <= w_held_inc;
                end else begin
                    r_held_dir <= r_dir;
                    r_held_cnt <= COUNT_BITS'(1);
                end
            end
        end
    end

    // Capture the transaction, products and write-back results
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mag  <= w_in_mag;
            r_dir  <= w_in_dir;
            r_slow <= i_slow_mode;
        end
        if (i_cmd.update && w_dead) begin
            r_pix <= '0;
        end
        if (i_cmd.mul) begin
            r_num <= w_prod[NUM_W-1:0];
            r_den <= w_den;
        end
        if (i_cmd.wb) begin
            unique case (i_cmd.op)
                OP_ZONE: begin
                    unique case (w_zone)
                        Z_PREC:  r_spd <= PREC_MIN_X100 + w_quot[11:0];
                        Z_LIN:   r_spd <= LIN_MIN_X100 + w_quot[11:0];
                        Z_ACCEL: r_t   <= w_quot[6:0];
                        Z_BURST: r_spd <= BURST_MIN_X100 + w_quot[11:0];
                        default: ;
                    endcase
                end
                OP_TSQ: r_spd <= ACCEL_MIN_X100 + {1'b0, w_quot[6:0], 4'b0000};
                OP_BOOST: begin
                    priority if (w_below_thr) r_boost <= r_boost_min;
                    else if (w_full)          r_boost <= r_boost_max;
                    else if (w_span_neg)      r_boost <= r_boost_min - w_quot[9:0];
                    else                      r_boost <= r_boost_min + w_quot[9:0];
                end
                OP_VAL:  r_val <= w_quot[15:0];
                OP_SLOW: r_val <= w_quot[15:0];
                OP_PIX:  r_pix <= (w_pix_raw > {7'b0, SPEED_LIMIT}) ? SPEED_LIMIT
                                                                  : w_pix_raw[8:0];
                default: ;
            endcase
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_speed <= (r_dir == DIR_NEG) ? $signed(10'd0 - w_pix_ext) : $signed(w_pix_ext);
        end
    end

    assign o_valid = r_out_valid;
    assign o_speed = r_speed;

    assign o_sts.dead         = w_dead;
    assign o_sts.quad         = (w_zone == Z_ACCEL);
    assign o_sts.boost_direct = w_below_thr | w_full;
    assign o_sts.slow         = r_slow;
    assign o_sts.val_ge100    = (r_val >= PERCENT);
    assign o_sts.div_done     = w_div_done;
    assign o_sts.out_free     = !r_out_valid || !i_stall;

endmodule

// ===== rtl/sacb_ctrl.sv =====
module sacb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  sacb_pkg::t_dp_sts i_sts,
    output sacb_pkg::t_dp_cmd o_cmd
);
    import sacb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_MUL,
        S_START,
        S_DIV,
        S_WB,
        S_OUT
    } t_state;

    t_state r_state;
    t_op    r_op;
    logic   r_stall;
    t_op    n_op;
    logic   w_skip;

    // Pick the operation after the current write-back
    always_comb begin
        n_op = OP_PIX;
        unique case (r_op)
            OP_ZONE:  n_op = i_sts.quad ? OP_TSQ : OP_BOOST;
            OP_TSQ:   n_op = OP_BOOST;
            OP_BOOST: n_op = OP_VAL;
            OP_VAL:   n_op = i_sts.slow ? OP_SLOW : OP_PIX;
            OP_SLOW:  n_op = OP_PIX;
            OP_PIX:   n_op = OP_PIX;
            default:  n_op = OP_PIX;
        endcase
    end

    // Operations whose result needs no division
    assign w_skip = (r_op == OP_BOOST && i_sts.boost_direct)
                 || (r_op == OP_PIX && !i_sts.val_ge100);

    // Sequence one transaction through the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_ZONE;
            r_stall <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_UPDATE;
                        r_stall <= 1'b1;
                    end
                end
                S_UPDATE: begin
                    if (i_sts.dead) begin
                        r_state <= S_OUT;
                    end else begin
                        r_op    <= OP_ZONE;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= w_skip ? S_WB : S_START;
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_sts.div_done) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (r_op == OP_PIX) begin
                        r_state <= S_OUT;
                    end else begin
                        r_op    <= n_op;
                        r_state <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                        r_stall <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall        = r_stall;
    assign o_cmd.accept   = (r_state == S_IDLE) && i_valid;
    assign o_cmd.update   = (r_state == S_UPDATE);
    assign o_cmd.mul      = (r_state == S_MUL);
    assign o_cmd.start    = (r_state == S_START);
    assign o_cmd.wb       = (r_state == S_WB);
    assign o_cmd.out_load = (r_state == S_OUT) && i_sts.out_free;
    assign o_cmd.op       = r_op;

endmodule

// ===== rtl/stick_accel_curve_with_boost.sv =====
// Joystick axis to cursor speed with a five-zone curve and a hold-time boost.
// Input channel: i_valid / o_stall carry one signed axis sample and the slow
// mode flag; a transaction is taken when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall carry one signed speed per sample.
// Configuration: write i_cfg_data to register i_cfg_idx with i_cfg_we, only
// while no transaction is in flight; unknown indexes are ignored.
// Sequencing: a dead sample goes from the update step straight to the output
// step. A live sample runs up to six multiply-divide operations through one
// shared divider that resolves 2 quotient bits per cycle; each operation
// steps through multiply, divider start, division and write-back, or goes
// straight from multiply to write-back when no division is needed. One
// sample is worked on at a time; the next is taken the cycle after its
// result enters the output register.
// When the receiver stalls, the result holds in the output register and the
// block holds o_stall high until that register is free for the next result.
// Reset (synchronous, active low) clears the boost counters and direction,
// restores the register defaults and empties the output register.
module stick_accel_curve_with_boost (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sacb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sacb_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [15:0]              i_deflection,
    input  logic                            i_slow_mode,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [9:0]               o_speed
);
    import sacb_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    sacb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    sacb_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_deflection (i_deflection),
        .i_slow_mode  (i_slow_mode),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_speed      (o_speed),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts)
    );

endmodule

// ===== tb/stick_accel_curve_with_boost_tb.sv =====
module stick_accel_curve_with_boost_tb;

    import sacb_pkg::*;

    localparam int     SETTLE_CYCLES  = 8;
    localparam int     DRAIN_CYCLES   = 150;
    localparam int     LONG_HOLD      = 600;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam longint PCT            = 100;
    localparam longint ACCEL_GAIN     = 16;

    typedef enum logic [1:0] {
        HEAD_NONE,
        HEAD_POS,
        HEAD_NEG
    } t_heading;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      data;
        logic signed [15:0]    defl;
        logic                  slow;
        bit                    pinned;
        logic signed [9:0]     speed;
    } t_row;

    // DUT ports
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = CFG_DEADZONE;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic signed [15:0]     i_deflection = '0;
    logic                   i_slow_mode = 1'b0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic signed [9:0]      o_speed;

    // Hand-worked speed travelling with the current transaction
    bit                     pin_on = 1'b0;
    logic signed [9:0]      pin_speed = '0;

    // Register shadows
    logic [13:0]            dz_reg;
    logic [15:0]            reset_frames_reg;
    logic [15:0]            threshold_reg;
    logic [15:0]            ramp_reg;
    logic [9:0]             boost_min_reg;
    logic [9:0]             boost_max_reg;
    logic [6:0]             slow_reg;

    // Boost integrator state
    logic [COUNT_BITS-1:0]  dead_run;
    logic [COUNT_BITS-1:0]  held_frames;
    t_heading               held_heading;

    logic signed [9:0]      speed_due[$];
    int                     fail_count = 0;
    int                     quiet_cycles = 0;
    int                     sender_idle_pct = 0;
    int                     receiver_stall_pct = 0;
    bit                     long_hold_req = 1'b0;
    t_row                   directed_plan[$];

    stick_accel_curve_with_boost uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_deflection (i_deflection),
        .i_slow_mode  (i_slow_mode),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_speed      (o_speed)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Restore register defaults and clear the integrator
    function automatic void reset_speed_model();
        dz_reg           = RST_DEADZONE;
        reset_frames_reg = RST_RESET_FRAMES;
        threshold_reg    = RST_THRESHOLD;
        ramp_reg         = RST_RAMP;
        boost_min_reg    = RST_BOOST_MIN;
        boost_max_reg    = RST_BOOST_MAX;
        slow_reg         = RST_SLOW;
        dead_run         = '0;
        held_frames      = '0;
        held_heading     = HEAD_NONE;
    endfunction

    function automatic longint interp(longint m, longint m0, longint m1,
                                      longint y0, longint y1);
        return y0 + ((m - m0) * (y1 - y0)) / (m1 - m0);
    endfunction

    // Advance the integrator by one frame and return the expected speed
    function automatic logic signed [9:0] predict_speed(logic signed [15:0] defl,
                                                        logic slow);
        longint   mag, spd, gain, pos, val, px, t, tsq;
        t_heading heading;
        heading = (defl > 0) ? HEAD_POS : ((defl < 0) ? HEAD_NEG : HEAD_NONE);
        mag = (defl < 0) ? -longint'(defl) : longint'(defl);

        // Dead frame: count it, clear the hold once enough have passed
        if (mag < longint'(dz_reg)) begin
            if (dead_run != {COUNT_BITS{1'b1}})
                dead_run++;
            if (dead_run >= reset_frames_reg) begin
                held_frames  = '0;
                held_heading = HEAD_NONE;
            end
            return '0;
        end
        dead_run = '0;
        if (held_heading != HEAD_NONE && held_heading == heading) begin
            if (held_frames != {COUNT_BITS{1'b1}})
                held_frames++;
        end else begin
            held_heading = heading;
            held_frames  = 1;
        end

        // Curve in hundredths
        if (mag < longint'(PREC_END)) begin
            spd = interp(mag, longint'(dz_reg), longint'(PREC_END),
                         longint'(PREC_MIN_X100), longint'(PREC_MAX_X100));
        end else if (mag < longint'(LIN_END)) begin
            spd = interp(mag, longint'(PREC_END), longint'(LIN_END),
                         longint'(LIN_MIN_X100), longint'(LIN_MAX_X100));
        end else if (mag < longint'(ACCEL_END)) begin
            t   = ((mag - longint'(LIN_END)) * PCT) / longint'(ACCEL_END - LIN_END);
            tsq = (t * t) / PCT;
            spd = longint'(ACCEL_MIN_X100) + tsq * ACCEL_GAIN;
        end else begin
            if (mag > longint'(MAG_TOP))
                mag = longint'(MAG_TOP);
            spd = interp(mag, longint'(ACCEL_END), longint'(MAG_TOP),
                         longint'(BURST_MIN_X100), longint'(BURST_MAX_X100));
        end

        // Boost factor: hold at minimum, ramp, then hold at maximum
        if (longint'(held_frames) < longint'(threshold_reg)) begin
            gain = longint'(boost_min_reg);
        end else begin
            pos = longint'(held_frames) - longint'(threshold_reg);
            if (pos >= longint'(ramp_reg))
                gain = longint'(boost_max_reg);
            else
                gain = longint'(boost_min_reg)
                     + ((longint'(boost_max_reg) - longint'(boost_min_reg)) * pos)
                     / longint'(ramp_reg);
        end

        val = (spd * gain) / PCT;
        if (slow)
            val = (val * longint'(slow_reg)) / PCT;
        if (val >= PCT)
            px = val / PCT;
        else if (val > 0)
            px = 1;
        else
            px = 0;
        if (px > longint'(SPEED_LIMIT))
            px = longint'(SPEED_LIMIT);
        if (heading == HEAD_NEG)
            px = -px;
        return px[9:0];
    endfunction

    function automatic t_row sample_row(logic signed [15:0] d, logic s, bit p,
                                        logic signed [9:0] v);
        t_row r;
        r.kind   = ROW_SAMPLE;
        r.idx    = CFG_DEADZONE;
        r.data   = '0;
        r.defl   = d;
        r.slow   = s;
        r.pinned = p;
        r.speed  = v;
        return r;
    endfunction

    function automatic t_row write_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        t_row r;
        r        = sample_row('0, 1'b0, 1'b0, '0);
        r.kind   = ROW_WRITE;
        r.idx    = idx;
        r.data   = v;
        return r;
    endfunction

    // Offer one transaction, with random gaps ahead of it, and hold until taken
    task automatic send_item(logic signed [15:0] d, logic s, bit p, logic signed [9:0] v);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_deflection <= d;
        i_slow_mode  <= s;
        pin_on       <= p;
        pin_speed    <= v;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drop valid and wait for every outstanding speed to come back
    task automatic quiesce();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (speed_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        case (idx)
            CFG_DEADZONE:     dz_reg           = v[13:0];
            CFG_RESET_FRAMES: reset_frames_reg = v[15:0];
            CFG_THRESHOLD:    threshold_reg    = v[15:0];
            CFG_RAMP:         ramp_reg         = v[15:0];
            CFG_BOOST_MIN:    boost_min_reg    = v[9:0];
            CFG_BOOST_MAX:    boost_max_reg    = v[9:0];
            CFG_SLOW:         slow_reg         = v[6:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_regs(int dz, int rf, int thr, int rmp, int bmin, int bmax,
                                int slw);
        write_reg(CFG_DEADZONE, CFG_W'(dz));
        write_reg(CFG_RESET_FRAMES, CFG_W'(rf));
        write_reg(CFG_THRESHOLD, CFG_W'(thr));
        write_reg(CFG_RAMP, CFG_W'(rmp));
        write_reg(CFG_BOOST_MIN, CFG_W'(bmin));
        write_reg(CFG_BOOST_MAX, CFG_W'(bmax));
        write_reg(CFG_SLOW, CFG_W'(slw));
    endtask

    // Magnitude at or above the deadzone, biased to the zone edges
    function automatic longint live_magnitude();
        longint lo, m;
        lo = longint'(dz_reg);
        case ($urandom_range(13))
            0:  m = lo;
            1:  m = lo + 1;
            2:  m = 11999;
            3:  m = longint'(PREC_END);
            4:  m = 21999;
            5:  m = longint'(LIN_END);
            6:  m = 29999;
            7:  m = longint'(ACCEL_END);
            8:  m = longint'(MAG_TOP);
            9:  m = 32768;
            default: m = longint'($urandom_range(32768, 0));
        endcase
        return (m < lo) ? lo + longint'($urandom_range(32768 - int'(lo))) : m;
    endfunction

    function automatic longint dead_magnitude();
        if (dz_reg == 0)
            return 0;
        if ($urandom_range(3) == 0)
            return longint'(dz_reg) - 1;
        return longint'($urandom_range(int'(dz_reg) - 1, 0));
    endfunction

    function automatic logic signed [15:0] signed_sample(bit neg, longint mag);
        if (neg)
            return 16'(-mag);
        return (mag > 32767) ? 16'sd32767 : 16'(mag);
    endfunction

    // Runs of held, dead and reversing frames with random content, plus noise
    task automatic run_random(int n_items);
        int               left, run_len, k, pick;
        bit               neg;
        logic signed [15:0] d;
        left = n_items;
        while (left > 0) begin
            pick = $urandom_range(99);
            neg  = $urandom_range(1);
            if (pick < 60)
                run_len = $urandom_range(60, 1);
            else if (pick < 80)
                run_len = $urandom_range(10, 1);
            else
                run_len = $urandom_range(8, 2);
            if (run_len > left)
                run_len = left;
            for (k = 0; k < run_len; k++) begin
                if (pick < 60)
                    d = signed_sample(neg, live_magnitude());
                else if (pick < 80)
                    d = signed_sample($urandom_range(1), dead_magnitude());
                else if (pick < 90)
                    d = signed_sample(neg ^ k[0], live_magnitude());
                else
                    d = 16'($urandom);
                send_item(d, $urandom_range(1), 1'b0, '0);
            end
            left -= run_len;
        end
    endtask

    // Receiver: random stall, with one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Record accepted samples, check accepted speeds, watch for a hang
    always @(posedge i_clk) begin : check_speed
        logic signed [9:0] want;
        bit                moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                want = predict_speed(i_deflection, i_slow_mode);
                if (pin_on)
                    want = pin_speed;
                speed_due.push_back(want);
                moved = 1'b1;
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                if (speed_due.size() == 0) begin
                    $error("speed: unexpected transaction, got %0d", o_speed);
                    fail_count++;
                end else begin
                    want = speed_due.pop_front();
                    if (o_speed !== want) begin
                        $error("speed: expected %0d, got %0d", want, o_speed);
                        fail_count++;
                    end
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        reset_speed_model();

        // Hand-worked frames at reset settings, then the special register settings
        directed_plan.push_back(sample_row(16'sd0, 1'b0, 1'b1, 10'sd0));
        directed_plan.push_back(sample_row(16'sd32767, 1'b0, 1'b1, 10'sd40));
        directed_plan.push_back(sample_row(16'sh8000, 1'b0, 1'b1, -10'sd40));
        directed_plan.push_back(sample_row(-16'sd32767, 1'b0, 1'b1, -10'sd40));
        directed_plan.push_back(sample_row(16'sd4499, 1'b0, 1'b1, 10'sd0));
        directed_plan.push_back(sample_row(16'sd4500, 1'b0, 1'b1, 10'sd1));
        directed_plan.push_back(sample_row(-16'sd4500, 1'b0, 1'b1, -10'sd1));
        directed_plan.push_back(sample_row(16'sd12000, 1'b0, 1'b1, 10'sd2));
        directed_plan.push_back(sample_row(16'sd22000, 1'b0, 1'b1, 10'sd8));
        directed_plan.push_back(sample_row(16'sd30000, 1'b0, 1'b1, 10'sd24));
        directed_plan.push_back(sample_row(16'sd29999, 1'b0, 1'b1, 10'sd23));
        directed_plan.push_back(sample_row(16'sd32767, 1'b1, 1'b1, 10'sd20));
        directed_plan.push_back(sample_row(16'sd4500, 1'b1, 1'b1, 10'sd1));
        // zero deadzone: a centred stick is live with no direction
        directed_plan.push_back(write_row(CFG_DEADZONE, 16'd0));
        directed_plan.push_back(sample_row(16'sd0, 1'b0, 1'b1, 10'sd1));
        directed_plan.push_back(sample_row(16'sd0, 1'b1, 1'b1, 10'sd1));
        // zero slow scale and zero boost
        directed_plan.push_back(write_row(CFG_SLOW, 16'd0));
        directed_plan.push_back(sample_row(16'sd32767, 1'b1, 1'b1, 10'sd0));
        directed_plan.push_back(write_row(CFG_BOOST_MIN, 16'd0));
        directed_plan.push_back(sample_row(16'sh8000, 1'b0, 1'b1, 10'sd0));
        // deadzone past the first zone
        directed_plan.push_back(write_row(CFG_DEADZONE, 16'd16383));
        directed_plan.push_back(sample_row(16'sd16382, 1'b0, 1'b1, 10'sd0));
        directed_plan.push_back(sample_row(16'sd16383, 1'b0, 1'b0, 10'sd0));
        // zero reset frames, then zero ramp with the minimum above the maximum
        directed_plan.push_back(write_row(CFG_RESET_FRAMES, 16'd0));
        directed_plan.push_back(sample_row(16'sd100, 1'b0, 1'b1, 10'sd0));
        directed_plan.push_back(write_row(CFG_SLOW, 16'd100));
        directed_plan.push_back(write_row(CFG_RAMP, 16'd0));
        directed_plan.push_back(write_row(CFG_THRESHOLD, 16'd2));
        directed_plan.push_back(write_row(CFG_BOOST_MIN, 16'd1000));
        directed_plan.push_back(write_row(CFG_BOOST_MAX, 16'd0));
        directed_plan.push_back(sample_row(-16'sd20000, 1'b0, 1'b0, 10'sd0));
        directed_plan.push_back(sample_row(-16'sd20000, 1'b0, 1'b0, 10'sd0));
        directed_plan.push_back(sample_row(-16'sd20000, 1'b1, 1'b0, 10'sd0));
        directed_plan.push_back(sample_row(16'sh8000, 1'b1, 1'b0, 10'sd0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[n]) begin
            if (directed_plan[n].kind == ROW_WRITE) begin
                quiesce();
                write_reg(directed_plan[n].idx, directed_plan[n].data);
            end else begin
                send_item(directed_plan[n].defl, directed_plan[n].slow,
                          directed_plan[n].pinned, directed_plan[n].speed);
            end
        end
        quiesce();

        // No idling: zero deadzone and threshold, shortest ramp
        program_regs(0, 1, 0, 1, 0, 1000, 100);
        run_random(150);
        quiesce();

        // Sender idle about half the time: top of the stated ranges
        sender_idle_pct = 51;
        program_regs(11999, 65535, 65535, 65535, 1000, 0, 0);
        run_random(150);
        quiesce();

        // Receiver stalling about half the time: downward ramp
        sender_idle_pct    = 0;
        receiver_stall_pct = 51;
        program_regs(3000, 3, 5, 20, 300, 50, 75);
        run_random(200);
        quiesce();

        // Both sides idling lightly: the narrow registers at full width, speed saturates
        sender_idle_pct    = 7;
        receiver_stall_pct = 7;
        program_regs(16383, 0, 2, 0, 1023, 1023, 127);
        run_random(150);
        quiesce();

        // Long receiver hold-off while the sender keeps offering
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        program_regs($urandom_range(11999, 0), $urandom_range(12, 1),
                     $urandom_range(40, 0), $urandom_range(40, 1),
                     $urandom_range(1000, 0), $urandom_range(1000, 0),
                     $urandom_range(100, 0));
        long_hold_req = 1'b1;
        run_random(200);
        quiesce();

        // Both sides idling heavily with random settings
        sender_idle_pct    = 51;
        receiver_stall_pct = 51;
        program_regs($urandom_range(11999, 0), $urandom_range(12, 1),
                     $urandom_range(40, 0), $urandom_range(40, 1),
                     $urandom_range(1000, 0), $urandom_range(1000, 0),
                     $urandom_range(100, 0));
        run_random(150);
        quiesce();

        // Back to reset settings
        sender_idle_pct    = 7;
        receiver_stall_pct = 7;
        program_regs(4500, 6, 10, 30, 100, 200, 50);
        run_random(200);
        quiesce();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sacb_pkg.sv
rtl/sacb_div.sv
rtl/sacb_dp.sv
rtl/sacb_ctrl.sv
rtl/stick_accel_curve_with_boost.sv
tb/stick_accel_curve_with_boost_tb.sv
